/* sv/swce_pkg.sv */
`timescale 1ns / 1ps

package swce_pkg;

  // Payload widths
  localparam int DATA_W = 32;
  localparam int RES_W  = 48;
  localparam int STAT_W = 2;
  localparam int ADDR_W = 4;
  localparam int REG_W  = 2;

  // Internal datapath widths
  localparam int NUM_W = 64;           // area * molar
  localparam int DEN_W = 63;           // mass * gravity
  localparam int KQ_W  = 104;          // capacity quotient, Q.32
  localparam int FRAC_SH = 40;         // numerator pre-shift
  localparam int DP_W  = 33;           // pressure difference, signed
  localparam int M_W   = 34;           // multiplier operand
  localparam int P1_W  = KQ_W + M_W;   // capacity times pressure term
  localparam int RO_W  = 31;           // rollover width
  localparam int Q2_W  = 73;           // smoothed slope quotient bits
  localparam int P2_W  = Q2_W + RO_W;  // slope times pressure
  localparam int GR_W  = 31;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZDIV = 2'd2;

  // Register indexes
  localparam logic [REG_W-1:0] REG_ALLOW_NEG = 2'd0;
  localparam logic [REG_W-1:0] REG_ROLLOVER  = 2'd1;
  localparam logic [REG_W-1:0] REG_ATM       = 2'd2;
  localparam logic [REG_W-1:0] REG_GRAVITY   = 2'd3;

  // Reset values
  localparam logic signed [DATA_W-1:0] ATM_RESET  = 32'sd25939200;
  localparam logic [GR_W-1:0]          GRAV_RESET = 31'd164528285;

  localparam logic [RES_W-1:0] POS_LIM = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic             sat;
  } clamp_t;

  // Saturate a magnitude to the 48-bit signed range and apply the sign
  function automatic clamp_t clamp_mag(input logic [127:0] mag, input logic neg);
    logic [127:0]     lim;
    logic [RES_W-1:0] m;
    clamp_t           r;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (mag > lim) begin
      r.sat = 1'b1;
      m = lim[RES_W-1:0];
    end else begin
      r.sat = 1'b0;
      m = mag[RES_W-1:0];
    end
    r.value = neg ? (48'd0 - m) : m;
    return r;
  endfunction

endpackage

/* sv/swce_if.sv */
`timescale 1ns / 1ps

// Cell input channel
interface swce_in_if;
  import swce_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pressure;
  logic [DATA_W-1:0]        cell_area;
  logic [DATA_W-1:0]        molar_density;
  logic [DATA_W-1:0]        mass_density;

  modport source (output valid, pressure, cell_area, molar_density, mass_density,
                  input ready);
  modport sink (input valid, pressure, cell_area, molar_density, mass_density,
                output ready);
endinterface

// Result channel
interface swce_out_if;
  import swce_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] water_content;
  logic signed [RES_W-1:0] content_slope;
  logic [STAT_W-1:0]       status;

  modport source (output valid, water_content, content_slope, status, input ready);
  modport sink (input valid, water_content, content_slope, status, output ready);
endinterface

/* sv/swce_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// in_rem is the partial remainder ahead of in_num and must be below in_den.
module swce_div #(
  parameter int DW = 63,
  parameter int QW = 104,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld  [QW];
  logic [DW-1:0] rem  [QW];
  logic [QW-1:0] numq [QW];
  logic [DW-1:0] den  [QW];
  logic [SW-1:0] side [QW];

  logic [DW-1:0] rem_next  [QW];
  logic [QW-1:0] numq_next [QW];

  // One compare-subtract per stage; quotient bits shift in from the right
  always_comb begin
    logic [DW-1:0] r_src;
    logic [QW-1:0] n_src;
    logic [DW-1:0] d_src;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    for (int g = 0; g < QW; g++) begin
      if (g == 0) begin
        r_src = in_rem;
        n_src = in_num;
        d_src = in_den;
      end else begin
        r_src = rem[g-1];
        n_src = numq[g-1];
        d_src = den[g-1];
      end
      t    = {r_src, n_src[QW-1]};
      diff = t - {1'b0, d_src};
      ge   = (t >= {1'b0, d_src});
      rem_next[g]  = ge ? diff[DW-1:0] : t[DW-1:0];
      numq_next[g] = {n_src[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < QW; g++) vld[g] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int g = 1; g < QW; g++) vld[g] <= vld[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den[0]  <= in_den;
      side[0] <= in_side;
      for (int g = 1; g < QW; g++) begin
        den[g]  <= den[g-1];
        side[g] <= side[g-1];
      end
      for (int g = 0; g < QW; g++) begin
        rem[g]  <= rem_next[g];
        numq[g] <= numq_next[g];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = numq[QW-1];
  assign out_side  = side[QW-1];

endmodule

/* sv/swce_mul.sv */
`timescale 1ns / 1ps

// Three-stage wide multiplier: chunked partial products, two half sums,
// final sum.
module swce_mul #(
  parameter int AW = 104,
  parameter int BW = 34,
  parameter int NC = 4,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [AW-1:0]    in_a,
  input  logic [BW-1:0]    in_b,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [AW+BW-1:0] out_prod,
  output logic [SW-1:0]    out_side
);

  localparam int CW   = (AW + NC - 1) / NC;
  localparam int AP   = NC * CW;
  localparam int PW   = AW + BW;
  localparam int HALF = NC / 2;
  localparam int PPW  = CW + BW;

  logic [AP-1:0]  a_pad;
  logic [PPW-1:0] pp [NC];
  logic           v1, v2, v3;
  logic [SW-1:0]  s1, s2, s3;
  logic [PW-1:0]  lo, hi, prod;
  logic [PW-1:0]  lo_next, hi_next;

  assign a_pad = AP'(in_a);

  // Half sums of the partial products
  always_comb begin
    lo_next = '0;
    hi_next = '0;
    for (int i = 0; i < HALF; i++) lo_next = lo_next + (PW'(pp[i]) << (i * CW));
    for (int i = HALF; i < NC; i++) hi_next = hi_next + (PW'(pp[i]) << ((i - HALF) * CW));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) pp[i] <= PPW'(a_pad[i*CW +: CW]) * PPW'(in_b);
      s1   <= in_side;
      lo   <= lo_next;
      hi   <= hi_next;
      s2   <= s1;
      prod <= lo + (hi << (HALF * CW));
      s3   <= s2;
    end
  end

  assign out_valid = v3;
  assign out_prod  = prod;
  assign out_side  = s3;

endmodule

/* sv/surface_water_content_eval_unit.sv */
`timescale 1ns / 1ps

// Surface water content evaluator. Each beat on cell_in carries one mesh cell
// (pressure, area, molar and mass density); one beat on cell_out returns its
// water content, the derivative by pressure, and a status (ok, saturated, zero
// divisor). Cells are fully independent and one is accepted every clock
// while the output buffer is not full. The input stage registers a beat at its
// accepting edge; its result passes the two restoring dividers (104 and
// 73 stages, one quotient bit per stage), the mode stage, two three-stage wide
// multipliers and the output buffer before it shows on cell_out. A two-entry
// output buffer lets the pipeline keep moving while a result waits; the input
// stalls only when that buffer is full. Registers are on an APB port at byte
// addresses 0, 4, 8, 12 and must be written while idle.
module surface_water_content_eval_unit (
  input  logic                         clk,
  input  logic                         rst,
  swce_in_if.sink                      cell_in,
  swce_out_if.source                   cell_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swce_pkg::ADDR_W-1:0]  paddr,
  input  logic [swce_pkg::DATA_W-1:0]  pwdata,
  output logic [swce_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import swce_pkg::*;

  typedef enum logic [1:0] {PATH_ZERO, PATH_LIN, PATH_ABOVE, PATH_RANGE} path_t;

  typedef struct packed {
    logic                   zero;
    logic signed [DP_W-1:0] dp;
  } d1side_t;

  typedef struct packed {
    path_t             path;
    logic              neg;
    logic              zero;
    logic [RO_W-1:0]   dp;
    logic [KQ_W-1:0]   kq;
  } m1side_t;

  typedef struct packed {
    logic              range;
    logic              big;
    logic              zero;
    logic [RES_W-1:0]  content;
    logic [RES_W-1:0]  slope;
    logic              sat;
    logic [RO_W-1:0]   dp;
  } d2side_t;

  typedef struct packed {
    logic              range;
    logic              big;
    logic              zero;
    logic [RES_W-1:0]  content;
    logic [RES_W-1:0]  slope;
    logic              sat;
    logic [Q2_W-1:0]   q;
  } m2side_t;

  typedef struct packed {
    logic [RES_W-1:0]  water_content;
    logic [RES_W-1:0]  content_slope;
    logic [STAT_W-1:0] status;
  } res_t;

  // Configuration registers
  logic                     allow_negative;
  logic [RO_W-1:0]          rollover;
  logic signed [DATA_W-1:0] ambient_pres;
  logic [GR_W-1:0]          downward_gravity;

  logic [REG_W-1:0] reg_idx;
  assign reg_idx = paddr[REG_W+1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_negative   <= 1'b0;
      rollover         <= '0;
      ambient_pres     <= ATM_RESET;
      downward_gravity <= GRAV_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ALLOW_NEG: allow_negative   <= pwdata[0];
        REG_ROLLOVER:  rollover         <= pwdata[RO_W-1:0];
        REG_ATM:       ambient_pres     <= pwdata;
        REG_GRAVITY:   downward_gravity <= pwdata[GR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ALLOW_NEG: prdata = DATA_W'(allow_negative);
      REG_ROLLOVER:  prdata = DATA_W'(rollover);
      REG_ATM:       prdata = ambient_pres;
      REG_GRAVITY:   prdata = DATA_W'(downward_gravity);
      default:       prdata = '0;
    endcase
  end

  // Pipeline advance: stalls only when the output buffer is full
  logic [1:0] fcnt;
  logic       en;
  logic       accept;
  assign en            = (fcnt != 2'd2);
  assign cell_in.ready = en;
  assign accept        = cell_in.valid && en;

  // Stage 0: numerator and divisor products, pressure difference
  logic                   v0;
  logic                   zero0;
  logic [NUM_W-1:0]       num0;
  logic [DEN_W-1:0]       den0;
  logic signed [DP_W-1:0] dp0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= accept;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0  <= NUM_W'(cell_in.cell_area) * NUM_W'(cell_in.molar_density);
      den0  <= DEN_W'(cell_in.mass_density) * DEN_W'(downward_gravity);
      zero0 <= (cell_in.mass_density == '0) || (downward_gravity == '0);
      dp0   <= DP_W'(cell_in.pressure) - DP_W'(ambient_pres);
    end
  end

  // Capacity quotient kq = num * 2^40 / den
  d1side_t         d1_in, d1_out;
  logic            vk;
  logic [KQ_W-1:0] kq;

  assign d1_in.zero = zero0;
  assign d1_in.dp   = dp0;

  swce_div #(.DW(DEN_W), .QW(KQ_W), .SW($bits(d1side_t))) u_div_cap (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .in_rem    ('0),
    .in_num    ({num0, {FRAC_SH{1'b0}}}),
    .in_den    (den0),
    .in_side   (d1_in),
    .out_valid (vk),
    .out_quo   (kq),
    .out_side  (d1_out)
  );

  // Stage 1: mode selection and multiplier operand
  logic           v1;
  m1side_t        s1;
  logic [M_W-1:0] m1;
  m1side_t        s1_next;
  logic [M_W-1:0] m1_next;

  always_comb begin
    logic                   dneg;
    logic [DP_W-1:0]        mag;
    logic                   lin;
    logic signed [DP_W-1:0] dp;
    dp   = d1_out.dp;
    dneg = dp[DP_W-1];
    mag  = dneg ? (DP_W'(0) - DP_W'(dp)) : DP_W'(dp);
    lin  = allow_negative || (rollover == '0);
    s1_next.path = PATH_ZERO;
    s1_next.neg  = 1'b0;
    s1_next.zero = d1_out.zero;
    s1_next.dp   = dp[RO_W-1:0];
    s1_next.kq   = kq;
    m1_next      = '0;
    if (lin) begin
      if (!(dneg && !allow_negative)) begin
        s1_next.path = PATH_LIN;
        s1_next.neg  = dneg;
        m1_next      = M_W'(mag);
      end
    end else if (!dneg) begin
      if (dp[DATA_W-1:0] < DATA_W'(rollover)) begin
        s1_next.path = PATH_RANGE;
        m1_next      = M_W'(dp[DATA_W-1:0]);
      end else begin
        s1_next.path = PATH_ABOVE;
        m1_next      = {dp[DP_W-1:0], 1'b0} - M_W'(rollover);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= vk;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      m1 <= m1_next;
    end
  end

  // kq times the pressure term
  logic            vp1;
  logic [P1_W-1:0] prod1;
  m1side_t         s1_out;

  swce_mul #(.AW(KQ_W), .BW(M_W), .NC(4), .SW($bits(m1side_t))) u_mul_cap (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .in_a      (s1.kq),
    .in_b      (m1),
    .in_side   (s1),
    .out_valid (vp1),
    .out_prod  (prod1),
    .out_side  (s1_out)
  );

  // Stage 2: linear and upper-branch results, setup for the slope division
  d2side_t         d2_in;
  logic [RO_W-1:0] rem2;
  logic [Q2_W-1:0] num2;

  always_comb begin
    logic [127:0] p128;
    clamp_t       cl_lin, cl_abv, cl_k;
    logic         big;
    p128   = (prod1[P1_W-1:128] != '0) ? {128{1'b1}} : prod1[127:0];
    cl_lin = clamp_mag(p128 >> 24, s1_out.neg);
    cl_abv = clamp_mag(p128 >> 25, 1'b0);
    cl_k   = clamp_mag(128'(s1_out.kq), 1'b0);
    big    = (p128[127:Q2_W] >= (128 - Q2_W)'(rollover));
    rem2   = big ? '0 : p128[Q2_W+RO_W-1:Q2_W];
    num2   = p128[Q2_W-1:0];
    d2_in.range   = (s1_out.path == PATH_RANGE);
    d2_in.big     = big;
    d2_in.zero    = s1_out.zero;
    d2_in.dp      = s1_out.dp;
    d2_in.content = '0;
    d2_in.slope   = '0;
    d2_in.sat     = 1'b0;
    case (s1_out.path)
      PATH_LIN: begin
        d2_in.content = cl_lin.value;
        d2_in.slope   = cl_k.value;
        d2_in.sat     = cl_lin.sat | cl_k.sat;
      end
      PATH_ABOVE: begin
        d2_in.content = cl_abv.value;
        d2_in.slope   = cl_k.value;
        d2_in.sat     = cl_abv.sat | cl_k.sat;
      end
      default: ;
    endcase
  end

  // Smoothed slope = kq*dp / rollover
  logic            vq;
  logic [Q2_W-1:0] q2;
  d2side_t         d2_out;

  swce_div #(.DW(RO_W), .QW(Q2_W), .SW($bits(d2side_t))) u_div_slope (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vp1),
    .in_rem    (rem2),
    .in_num    (num2),
    .in_den    (rollover),
    .in_side   (d2_in),
    .out_valid (vq),
    .out_quo   (q2),
    .out_side  (d2_out)
  );

  // Smoothed slope times dp
  m2side_t         m2_in, m2_out;
  logic            vp2;
  logic [P2_W-1:0] prod2;

  assign m2_in.range   = d2_out.range;
  assign m2_in.big     = d2_out.big;
  assign m2_in.zero    = d2_out.zero;
  assign m2_in.content = d2_out.content;
  assign m2_in.slope   = d2_out.slope;
  assign m2_in.sat     = d2_out.sat;
  assign m2_in.q       = q2;

  swce_mul #(.AW(Q2_W), .BW(RO_W), .NC(4), .SW($bits(m2side_t))) u_mul_slope (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vq),
    .in_a      (q2),
    .in_b      (d2_out.dp),
    .in_side   (m2_in),
    .out_valid (vp2),
    .out_prod  (prod2),
    .out_side  (m2_out)
  );

  // Final selection and status
  res_t fin;

  always_comb begin
    clamp_t cl_c, cl_s;
    logic   sat;
    cl_c = clamp_mag(128'(prod2 >> 25), 1'b0);
    cl_s = clamp_mag(128'(m2_out.q), 1'b0);
    fin.water_content = m2_out.content;
    fin.content_slope = m2_out.slope;
    sat               = m2_out.sat;
    if (m2_out.range) begin
      if (m2_out.big) begin
        fin.water_content = POS_LIM;
        fin.content_slope = POS_LIM;
        sat               = 1'b1;
      end else begin
        fin.water_content = cl_c.value;
        fin.content_slope = cl_s.value;
        sat               = cl_c.sat | cl_s.sat;
      end
    end
    if (m2_out.zero) begin
      fin.water_content = '0;
      fin.content_slope = '0;
      fin.status        = ST_ZDIV;
    end else begin
      fin.status = sat ? ST_SAT : ST_OK;
    end
  end

  // Two-entry output buffer
  res_t buf0, buf1;
  logic push, pop;
  assign push = en && vp2;
  assign pop  = cell_out.valid && cell_out.ready;

  always_ff @(posedge clk) begin
    if (rst) fcnt <= 2'd0;
    else fcnt <= fcnt + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (fcnt == 2'd0) buf0 <= fin;
        else buf1 <= fin;
      end
      2'b01: buf0 <= buf1;
      2'b11: begin
        if (fcnt == 2'd1) begin
          buf0 <= fin;
        end else begin
          buf0 <= buf1;
          buf1 <= fin;
        end
      end
      default: ;
    endcase
  end

  assign cell_out.valid         = (fcnt != 2'd0);
  assign cell_out.water_content = buf0.water_content;
  assign cell_out.content_slope = buf0.content_slope;
  assign cell_out.status        = buf0.status;

endmodule

/* dv/surface_water_content_eval_unit_test.sv */
`timescale 1ns / 1ps

module surface_water_content_eval_unit_test;
  import swce_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] pressure;
    logic [DATA_W-1:0]        area;
    logic [DATA_W-1:0]        molar;
    logic [DATA_W-1:0]        mass;
  } cell_t;

  typedef struct {
    logic signed [RES_W-1:0] content;
    logic signed [RES_W-1:0] slope;
    logic [STAT_W-1:0]       status;
  } content_t;

  // Scoreboard: mirrors the registers and predicts water content per cell
  class content_board;
    logic                     allow_neg;
    logic [RO_W-1:0]          rollover;
    logic signed [DATA_W-1:0] atm;
    logic [GR_W-1:0]          gravity;
    content_t                 expected_q[$];
    int                       errors;

    function new();
      allow_neg = 1'b0;
      rollover  = '0;
      atm       = ATM_RESET;
      gravity   = GRAV_RESET;
      errors    = 0;
    endfunction

    function void write_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_ALLOW_NEG: allow_neg = val[0];
        REG_ROLLOVER:  rollover  = val[RO_W-1:0];
        REG_ATM:       atm       = val;
        REG_GRAVITY:   gravity   = val[GR_W-1:0];
        default: ;
      endcase
    endfunction

    // 128-bit product held at all ones on overflow
    function logic [127:0] mul_hold(logic [127:0] a, logic [63:0] b);
      logic [191:0] p;
      p = {64'b0, a} * {128'b0, b};
      return (p[191:128] != 0) ? {128{1'b1}} : p[127:0];
    endfunction

    function logic [RES_W-1:0] clamp(logic [127:0] mag, logic neg, inout logic sat);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
      if (mag > lim) begin
        sat = 1'b1;
        mag = lim;
      end
      return neg ? (48'd0 - mag[RES_W-1:0]) : mag[RES_W-1:0];
    endfunction

    function void note_cell(cell_t c);
      logic [63:0]  den;
      logic [63:0]  num;
      logic [127:0] kq;
      logic [127:0] cont;
      logic [127:0] slp;
      logic [63:0]  mag;
      longint       dp;
      logic         neg;
      logic         sat;
      content_t     r;
      den = {32'b0, c.mass} * {33'b0, gravity};
      dp  = longint'(c.pressure) - longint'(atm);
      neg = 1'b0;
      sat = 1'b0;
      if (den == 0) begin
        r.content = '0;
        r.slope   = '0;
        r.status  = ST_ZDIV;
        expected_q.push_back(r);
        return;
      end
      num  = {32'b0, c.area} * {32'b0, c.molar};
      kq   = ({64'b0, num} << FRAC_SH) / {64'b0, den};
      cont = '0;
      slp  = '0;
      if (allow_neg || rollover == 0) begin
        if (!(dp < 0 && !allow_neg)) begin
          neg  = dp < 0;
          mag  = neg ? -dp : dp;
          cont = mul_hold(kq, mag) >> 24;
          slp  = kq;
        end
      end else if (dp >= 0) begin
        if (dp < longint'(rollover)) begin
          slp  = mul_hold(kq, dp) / {97'b0, rollover};
          cont = mul_hold(slp, dp) >> 25;
        end else begin
          slp  = kq;
          cont = mul_hold(kq, 2 * dp - longint'(rollover)) >> 25;
        end
      end
      r.content = clamp(cont, neg, sat);
      r.slope   = clamp(slp, 1'b0, sat);
      r.status  = sat ? ST_SAT : ST_OK;
      expected_q.push_back(r);
    endfunction

    function void check_result(content_t got);
      content_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result content=%h slope=%h status=%0d",
                 $time, got.content, got.slope, got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.content !== e.content) begin
        $display("%0t: water_content expected %h got %h", $time, e.content, got.content);
        errors++;
      end
      if (got.slope !== e.slope) begin
        $display("%0t: content_slope expected %h got %h", $time, e.slope, got.slope);
        errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic no_idle;

  content_board board;

  swce_in_if  cell_in ();
  swce_out_if cell_out ();

  surface_water_content_eval_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cell_in  (cell_in.sink),
    .cell_out (cell_out.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #20_000_000;
    $display("surface_water_content_eval_unit_test: FAIL");
    $finish;
  end

  // Register write over APB, setup then access
  task automatic reg_write(logic [REG_W-1:0] idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // One input beat; valid stays high into the next item when there is no gap
  task automatic send_cell(cell_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      cell_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_in.valid         <= 1'b1;
    cell_in.pressure      <= c.pressure;
    cell_in.cell_area     <= c.area;
    cell_in.molar_density <= c.molar;
    cell_in.mass_density  <= c.mass;
    do @(posedge clk); while (!cell_in.ready);
    board.note_cell(c);
  endtask

  function automatic logic [DATA_W-1:0] rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'h0001_0000 + $urandom_range(0, 32'hFFFF);
      2: return $urandom_range(1, 32'h003F_FFFF);
      default: return $urandom_range(0, 255) << 16;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t  c;
    longint span;
    span = (board.rollover != 0) ? 2 * longint'(board.rollover) + 16 : 4096;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    if ($urandom_range(0, 3) == 0)
      c.pressure = $urandom;
    else
      c.pressure = DATA_W'(longint'(board.atm) +
                          longint'($urandom_range(0, 2 * span)) - span);
    c.area  = rand_q16();
    c.molar = rand_q16();
    c.mass  = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_q16();
    return c;
  endfunction

  function automatic cell_t mk_cell(longint p, logic [31:0] a, logic [31:0] m,
                                    logic [31:0] ms);
    cell_t c;
    c.pressure = DATA_W'(p);
    c.area     = a;
    c.molar    = m;
    c.mass     = ms;
    return c;
  endfunction

  // Corner cells around the current setting
  task automatic directed_cells();
    longint a;
    longint r;
    a = longint'(board.atm);
    r = longint'(board.rollover);
    send_cell(mk_cell(a, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_cell(mk_cell(a - 1, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000));
    send_cell(mk_cell(a + 1, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000));
    send_cell(mk_cell(a + r - 1, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000));
    send_cell(mk_cell(a + r, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000));
    send_cell(mk_cell(-64'sh8000_0000, '1, '1, 32'd1));
    send_cell(mk_cell(64'sh7FFF_FFFF, '1, '1, 32'd1));
    send_cell(mk_cell(a + 256, 32'd0, '1, '1));
    send_cell(mk_cell(a + 256, '1, '1, 32'd0));
  endtask

  // Result side with random stalls
  initial begin
    content_t got;
    int       stall;
    cell_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        cell_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cell_out.ready <= 1'b1;
      do @(posedge clk); while (!cell_out.valid);
      got.content = cell_out.water_content;
      got.slope   = cell_out.content_slope;
      got.status  = cell_out.status;
      board.check_result(got);
    end
  end

  initial begin
    logic [DATA_W-1:0] phase_cfg [7][4];
    board                 = new();
    no_idle               = 1'b0;
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cell_in.valid         = 1'b0;
    cell_in.pressure      = '0;
    cell_in.cell_area     = '0;
    cell_in.molar_density = '0;
    cell_in.mass_density  = '0;
    // allow_neg, rollover, atmospheric, gravity per phase
    phase_cfg[0] = '{32'd0, 32'd0, ATM_RESET, DATA_W'(GRAV_RESET)};
    phase_cfg[1] = '{32'd1, 32'd0, ATM_RESET, DATA_W'(GRAV_RESET)};
    phase_cfg[2] = '{32'd0, 32'd2560, ATM_RESET, DATA_W'(GRAV_RESET)};
    phase_cfg[3] = '{32'd1, 32'd65536, 32'd0, 32'h0100_0000};
    phase_cfg[4] = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    phase_cfg[5] = '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'd0};
    phase_cfg[6] = '{32'd0, $urandom_range(1, 32'hFFFFF), $urandom,
                     $urandom_range(1, 32'h7FFF_FFFF)};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_cells();
    for (int ph = 0; ph < 7; ph++) begin
      cell_in.valid <= 1'b0;
      wait_drained();
      reg_write(REG_ALLOW_NEG, phase_cfg[ph][0]);
      reg_write(REG_ROLLOVER, phase_cfg[ph][1]);
      reg_write(REG_ATM, phase_cfg[ph][2]);
      reg_write(REG_GRAVITY, phase_cfg[ph][3]);
      if (ph > 0) directed_cells();
      for (int i = 0; i < 56; i++) begin
        if (i % 32 == 0) no_idle = ($urandom_range(0, 2) == 0);
        // hold off once until the pipeline drains
        if (ph == 2 && i == 30) begin
          cell_in.valid <= 1'b0;
          while (board.expected_q.size() != 0) @(posedge clk);
        end
        send_cell(rand_cell());
      end
    end
    cell_in.valid <= 1'b0;
    no_idle = 1'b0;
    wait_drained();

    if (board.errors == 0) begin
      $display("surface_water_content_eval_unit_test: PASS");
    end else begin
      $display("surface_water_content_eval_unit_test: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/swce_pkg.sv
sv/swce_if.sv
sv/swce_div.sv
sv/swce_mul.sv
sv/surface_water_content_eval_unit.sv
dv/surface_water_content_eval_unit_test.sv
